// File: rtl/npcs_pkg.sv
// Shared types, constants and the color distance function for the
// nearest palette color search. No dependencies.
package npcs_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W = 8;
	localparam int COMP_W = 8;
	localparam int DIST_W = 18;

	localparam logic FUNC_MATCH = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	// word traveling down the cell row: the input item plus the running best
	typedef struct packed {
		logic valid;
		logic func;
		logic [IDX_W-1:0] idx;
		logic [COMP_W-1:0] red;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] blue;
		logic [DIST_W-1:0] best_dist;
		logic [IDX_W-1:0] best_idx;
	} word_t;

	function automatic logic [DIST_W-1:0] color_dist(
		input logic [COMP_W-1:0] ar,
		input logic [COMP_W-1:0] ag,
		input logic [COMP_W-1:0] ab,
		input logic [COMP_W-1:0] br,
		input logic [COMP_W-1:0] bg,
		input logic [COMP_W-1:0] bb
	);
		logic [COMP_W-1:0] dr;
		logic [COMP_W-1:0] dg;
		logic [COMP_W-1:0] db;
		logic [2*COMP_W-1:0] sr;
		logic [2*COMP_W-1:0] sg;
		logic [2*COMP_W-1:0] sb;
		dr = (ar >= br) ? ar - br : br - ar;
		dg = (ag >= bg) ? ag - bg : bg - ag;
		db = (ab >= bb) ? ab - bb : bb - ab;
		sr = (2*COMP_W)'(dr) * (2*COMP_W)'(dr);
		sg = (2*COMP_W)'(dg) * (2*COMP_W)'(dg);
		sb = (2*COMP_W)'(db) * (2*COMP_W)'(db);
		return DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
	endfunction

endpackage

// File: rtl/npcs_cell.sv
// One palette cell: holds one palette entry, captures load words addressed
// to it and folds its distance into the running best of match words.
// Depends on npcs_pkg.
module npcs_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic advance,
	input  logic [npcs_pkg::IDX_W-1:0] cell_id,
	input  npcs_pkg::word_t word_in,
	output npcs_pkg::word_t word_out
);
	import npcs_pkg::*;

	logic [3*COMP_W-1:0] entry_q;
	word_t w_s1;
	word_t w_s2;
	logic [DIST_W-1:0] dist_s1;
	logic hit;

	assign hit = word_in.valid && (word_in.func == FUNC_LOAD) && (word_in.idx == cell_id);

	// entry changes as the load word passes, so earlier matches saw the old color
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (advance && hit) begin
			entry_q <= {word_in.red, word_in.green, word_in.blue};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_s1 <= '0;
			w_s2 <= '0;
			dist_s1 <= '0;
		end else if (advance) begin
			w_s1.valid <= word_in.valid;
			w_s1.func <= word_in.func;
			w_s1.idx <= word_in.idx;
			w_s1.red <= word_in.red;
			w_s1.green <= word_in.green;
			w_s1.blue <= word_in.blue;
			w_s1.best_dist <= word_in.best_dist;
			w_s1.best_idx <= word_in.best_idx;
			dist_s1 <= color_dist(word_in.red, word_in.green, word_in.blue,
				entry_q[3*COMP_W-1:2*COMP_W], entry_q[2*COMP_W-1:COMP_W],
				entry_q[COMP_W-1:0]);
			w_s2.valid <= w_s1.valid;
			w_s2.func <= w_s1.func;
			w_s2.idx <= w_s1.idx;
			w_s2.red <= w_s1.red;
			w_s2.green <= w_s1.green;
			w_s2.blue <= w_s1.blue;
			// strict less-than keeps the lower index on a tie
			if ((w_s1.func == FUNC_MATCH) && (dist_s1 < w_s1.best_dist)) begin
				w_s2.best_dist <= dist_s1;
				w_s2.best_idx <= cell_id;
			end else begin
				w_s2.best_dist <= w_s1.best_dist;
				w_s2.best_idx <= w_s1.best_idx;
			end
		end
	end

	assign word_out = w_s2;

	a_load_writes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && hit |=> entry_q == $past({word_in.red, word_in.green, word_in.blue}))
		else $error("load word did not update its palette cell");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(w_s2.valid) && $stable(w_s2.best_idx))
		else $error("cell output moved during stall");

	a_best_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		advance && w_s1.valid |=> w_s2.best_dist <= $past(w_s1.best_dist))
		else $error("running best distance grew");

	a_other_entry_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && hit) |=> $stable(entry_q))
		else $error("palette entry changed without a load word");

endmodule

// File: rtl/nearest_palette_color_search.sv
// Top level of the nearest palette color search: a row of palette cells
// and the output register. Depends on npcs_pkg and npcs_cell.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per item. func = 0
//   matches the pixel red/green/blue against the palette; func = 1 writes
//   red/green/blue into palette entry entry_index and gives no result.
//   Output channel (out_valid/out_ready) returns nearest_index for each
//   match, in order: the entry at least squared RGB distance, lowest index
//   on ties.
//   Every word walks the row of 256 cells, two register stages per cell
//   (distance, then compare), then the output register: 2*256+1 = 513
//   stages, the first loaded at the accepting edge. One word is accepted
//   per cycle unless a pending result stalls the row; loads and matches
//   may be mixed freely, each match sees the palette as left by the
//   words accepted before it.
//   When the receiver stalls with a result pending, the whole row freezes
//   and in_ready drops until the result is taken.
//   Reset empties the row and clears every palette entry to black.
module nearest_palette_color_search (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic func,
	input  logic [npcs_pkg::IDX_W-1:0] entry_index,
	input  logic [npcs_pkg::COMP_W-1:0] red,
	input  logic [npcs_pkg::COMP_W-1:0] green,
	input  logic [npcs_pkg::COMP_W-1:0] blue,
	output logic out_valid,
	input  logic out_ready,
	output logic [npcs_pkg::IDX_W-1:0] nearest_index
);
	import npcs_pkg::*;

	word_t chain [PALETTE_ENTRIES+1];
	word_t tail;
	logic advance;
	logic out_valid_q;
	logic [IDX_W-1:0] nearest_index_q;

	assign advance = !out_valid_q || out_ready;
	assign in_ready = advance;

	// all-ones start distance exceeds any real distance, so cell 0 always wins it
	always_comb begin
		chain[0].valid = in_valid;
		chain[0].func = func;
		chain[0].idx = entry_index;
		chain[0].red = red;
		chain[0].green = green;
		chain[0].blue = blue;
		chain[0].best_dist = '1;
		chain[0].best_idx = '0;
	end

	for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
		npcs_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.advance(advance),
			.cell_id(IDX_W'(i)),
			.word_in(chain[i]),
			.word_out(chain[i+1])
		);
	end

	assign tail = chain[PALETTE_ENTRIES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= tail.valid && (tail.func == FUNC_MATCH);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			nearest_index_q <= tail.best_idx;
		end
	end

	assign out_valid = out_valid_q;
	assign nearest_index = nearest_index_q;

	a_result_from_match: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(tail.valid && (tail.func == FUNC_MATCH)))
		else $error("result raised without a match word at the row end");

	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tail.valid && (tail.func == FUNC_LOAD) |=> !out_valid_q)
		else $error("load word produced a result");

	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> $stable(tail.valid) && $stable(tail.best_idx))
		else $error("row moved while result stalled");

endmodule
